[design/rbfe_pkg.sv]
// rbfe_pkg: shared widths, constants, controller state type and the command
// and status structs between the burst extractor controller and datapath.
// No dependencies.
package rbfe_pkg;

  localparam int LEVEL_W    = 8;
  localparam int RUN_W      = 16;
  localparam int ACC_W      = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int MEAN_SHIFT = 4;
  localparam int MEAN_W     = ACC_W + MEAN_SHIFT;
  localparam int DIV_STEPS  = MEAN_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 144;
  localparam int OUT_USED_W = ACC_W + MEAN_W + TIME_W + COUNT_W + 2 * TIME_W + 1;

  localparam int MAX_BURSTS_DEF = 128;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST  = 8'd16;
  localparam logic [LEVEL_W-1:0] FREE_LEVEL_TOP = 8'd1;

  localparam logic KIND_BURST   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_CHECK,
    ST_DIV,
    ST_BURST,
    ST_FREE,
    ST_SUMMARY
  } ctrl_state_e;

  typedef struct packed {
    logic load_item;
    logic busy_upd;
    logic free_upd;
    logic div_start;
    logic load_burst;
    logic burst_last;
    logic load_summary;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic busy;
    logic in_burst;
    logic size_nz;
    logic item_last;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

[design/rbfe_div.sv]
// rbfe_div: restoring serial divider, one quotient bit per cycle.
// Used by rbfe_datapath for the weighted mean; depends on rbfe_pkg.
module rbfe_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rbfe_pkg::MEAN_W-1:0] dividend_i,
  input  logic [rbfe_pkg::ACC_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [rbfe_pkg::MEAN_W-1:0] quotient_o
);
  import rbfe_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0]     rem_q, rem_d;
  logic [ACC_W-1:0]     dvs_q, dvs_d;
  logic [MEAN_W-1:0]    quo_q, quo_d;
  logic [ACC_W:0]       trial;
  logic                 ge;

  // partial remainder stays below the divisor, so the trial fits in 17 bits
  assign trial = {rem_q, quo_q[MEAN_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? ACC_W'(trial - {1'b0, dvs_q}) : trial[ACC_W-1:0];
      quo_d = {quo_q[MEAN_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/rbfe_datapath.sv]
// rbfe_datapath: item register, record accumulators, level limit register,
// serial mean divider and the result register. Depends on rbfe_pkg, rbfe_div.
module rbfe_datapath #(
  parameter int MAX_BURSTS = rbfe_pkg::MAX_BURSTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rbfe_pkg::ctrl_cmd_t             cmd_i,
  output rbfe_pkg::dp_status_t            status_o,
  input  logic [rbfe_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic                            in_last_i,
  input  logic                            cfg_we_i,
  input  logic [rbfe_pkg::LEVEL_W-1:0]    cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rbfe_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_kind_o,
  output logic                            out_last_o
);
  import rbfe_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_BURSTS);

  logic [LEVEL_W-1:0] max_level_q;
  logic [LEVEL_W-1:0] level_q;
  logic [RUN_W-1:0]   run_q;
  logic               last_q;

  logic               in_burst_q, in_burst_d;
  logic [ACC_W-1:0]   size_q, size_d;
  logic [ACC_W-1:0]   weight_q, weight_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [TIME_W-1:0]  free_q, free_d;
  logic [TIME_W-1:0]  busy_q, busy_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic               out_valid_q, out_valid_d;
  logic [OUT_USED_W-1:0] out_data_q, out_data_d;
  logic               out_kind_q, out_kind_d;
  logic               out_last_q, out_last_d;

  logic               skip, busy_item, full;
  logic [ACC_W-1:0]   product;
  logic               div_done;
  logic [MEAN_W-1:0]  mean;
  logic [TIME_W-1:0]  start_time;

  assign skip      = !in_burst_q && (level_q > max_level_q);
  assign busy_item = !skip && (level_q > FREE_LEVEL_TOP);
  assign full      = count_q >= MaxCount;
  assign product   = ACC_W'(level_q) * run_q;
  assign start_time = elapsed_q - TIME_W'(size_q);

  rbfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({weight_q, {MEAN_SHIFT{1'b0}}}),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .quotient_o (mean)
  );

  always_comb begin
    status_o.skip      = skip;
    status_o.busy      = busy_item;
    status_o.in_burst  = in_burst_q;
    status_o.size_nz   = size_q != '0;
    status_o.item_last = last_q;
    status_o.div_done  = div_done;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    in_burst_d  = in_burst_q;
    size_d      = size_q;
    weight_d    = weight_q;
    elapsed_d   = elapsed_q;
    free_d      = free_q;
    busy_d      = busy_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;

    if (cmd_i.busy_upd) begin
      in_burst_d = 1'b1;
      size_d     = size_q + run_q;
      weight_d   = weight_q + product;
      busy_d     = busy_q + TIME_W'(run_q);
      elapsed_d  = elapsed_q + TIME_W'(run_q);
    end
    if (cmd_i.free_upd) begin
      in_burst_d = 1'b0;
      size_d     = '0;
      weight_d   = '0;
      free_d     = free_q + TIME_W'(run_q);
      elapsed_d  = elapsed_q + TIME_W'(run_q);
    end
    if (cmd_i.load_burst) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_BURST;
      out_last_d  = cmd_i.burst_last;
      out_data_d  = {full, busy_q, free_q, (full ? MaxCount : count_q),
                     start_time, mean, size_q};
      in_burst_d  = 1'b0;
      size_d      = '0;
      weight_d    = '0;
      if (!full) begin
        count_d = count_q + 1'b1;
      end
    end
    if (cmd_i.load_summary) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_SUMMARY;
      out_last_d  = 1'b1;
      out_data_d  = {full, busy_q, free_q, count_q, {TIME_W{1'b0}},
                     {MEAN_W{1'b0}}, {ACC_W{1'b0}}};
      in_burst_d  = 1'b0;
      size_d      = '0;
      weight_d    = '0;
      elapsed_d   = '0;
      free_d      = '0;
      busy_d      = '0;
      count_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MAX_LEVEL_RST;
      in_burst_q  <= 1'b0;
      size_q      <= '0;
      weight_q    <= '0;
      elapsed_q   <= '0;
      free_q      <= '0;
      busy_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_level_q <= cfg_data_i;
      end
      in_burst_q  <= in_burst_d;
      size_q      <= size_d;
      weight_q    <= weight_d;
      elapsed_q   <= elapsed_d;
      free_q      <= free_d;
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      level_q <= in_data_i[LEVEL_W-1:0];
      run_q   <= in_data_i[LEVEL_W+RUN_W-1:LEVEL_W];
      last_q  <= in_last_i;
    end
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_data_q};
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

[design/rbfe_ctrl.sv]
// rbfe_ctrl: controller state machine sequencing entry update, burst close,
// mean division and result loads. Depends on rbfe_pkg.
module rbfe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rbfe_pkg::dp_status_t status_i,
  output rbfe_pkg::ctrl_cmd_t  cmd_o
);
  import rbfe_pkg::*;

  ctrl_state_e state_q, state_d;
  // set while the burst being closed was ended by a free entry
  logic        close_free_q, close_free_d;
  logic        close_ok;

  assign close_ok = status_i.in_burst && status_i.size_nz;

  always_comb begin
    state_d      = state_q;
    close_free_d = close_free_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!status_i.skip && !status_i.busy && close_ok) begin
          close_free_d = 1'b1;
          state_d      = ST_DIV;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status_i.item_last) begin
          state_d = ST_IDLE;
        end else if (close_ok) begin
          close_free_d = 1'b0;
          state_d      = ST_DIV;
        end else begin
          state_d = ST_SUMMARY;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_BURST;
        end
      end
      ST_BURST: begin
        if (status_i.out_free) begin
          state_d = close_free_q ? ST_FREE : ST_SUMMARY;
        end
      end
      ST_FREE: begin
        state_d = ST_CHECK;
      end
      ST_SUMMARY: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_APPLY: begin
        if (status_i.busy) begin
          cmd_o.busy_upd = 1'b1;
        end else if (!status_i.skip) begin
          if (close_ok) begin
            cmd_o.div_start = 1'b1;
          end else begin
            cmd_o.free_upd = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.item_last && close_ok) begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIV: begin
      end
      ST_BURST: begin
        cmd_o.load_burst = status_i.out_free;
        cmd_o.burst_last = close_free_q && !status_i.item_last;
      end
      ST_FREE: begin
        cmd_o.free_upd = 1'b1;
      end
      ST_SUMMARY: begin
        cmd_o.load_summary = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      close_free_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      close_free_q <= close_free_d;
    end
  end

endmodule

[design/rssi_burst_feature_extractor_top.sv]
// RSSI burst feature extractor. Takes run-length coded power entries one at a
// time and emits a feature beat per closed burst (size, weighted mean level
// times 16, start time) and a summary beat on the last entry of a record.
// An entry that closes no burst passes through the apply and check states (and
// the summary load on a last entry); a burst that closes also runs the serial
// divider for the mean (20 quotient bits and its done flag), then the result
// load and, for a burst ended by a free entry, the free update. Results sit in
// an output register while the next entry is taken; a stalled consumer holds
// the block only when a further result must be loaded. Depends on rbfe_pkg,
// rbfe_ctrl, rbfe_datapath and rbfe_div.
module rssi_burst_feature_extractor_top #(
  parameter int MAX_BURSTS = rbfe_pkg::MAX_BURSTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // level [7:0], run_len [23:8]
  input  logic [rbfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // burst_len [15:0], mean_level_x16 [35:16], start_time [67:36],
  // burst_index [75:68], free_total [107:76], busy_total [139:108],
  // overflow [140], zero fill [143:141]
  output logic [rbfe_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // kind [0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbfe_pkg::LEVEL_W-1:0]    cfg_data_i
);
  import rbfe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rbfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rbfe_datapath #(
    .MAX_BURSTS (MAX_BURSTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
